@@ sv/bir_pkg.sv @@
package bir_pkg;

  // Default frame store geometry
  localparam int MAX_ROWS_DEF = 128;
  localparam int MAX_COLS_DEF = 128;

  // Field and register widths
  localparam int IN_W       = 8;   // source size registers
  localparam int DEST_W     = 11;  // destination size registers
  localparam int COORD_W    = 10;  // row / column fields
  localparam int PIX_W      = 16;  // signed Q8.8 pixel
  localparam int VAL_W      = 15;  // result value
  localparam int FRAC_W     = 16;  // Q16 fraction bits
  localparam int DVD_W      = IN_W + FRAC_W;  // ratio dividend and quotient
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [DEST_W-1:0] DEST_MAX = 11'd1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_COLS = 2'd3;

  // Register reset values
  localparam logic [IN_W-1:0]   SRC_RST  = 8'd128;
  localparam logic [DEST_W-1:0] DEST_RST = 11'd128;

  // Function codes
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage

@@ sv/bir_div.sv @@
module bir_div
  import bir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DEST_W-1:0] divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DEST_W-1:0] rem_r;
  logic [DEST_W-1:0] dvs_r;
  logic [DVD_W-1:0]  quo_r;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  logic [DEST_W:0]   trial;
  logic              fits;
  logic [DEST_W:0]   trial_sub;

  assign trial     = {rem_r, quo_r[DVD_W-1]};
  assign fits      = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Hold the partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[DEST_W-1:0] : trial[DEST_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/bilinear_image_resizer_top.sv @@
// Write words: no result; the block stays ready for the next word.
// Request words: the 24-step shared divider runs once per axis to form the
// Q8.16 ratio, then four frame store reads and six multiply/add steps.
// Out-of-range requests go straight to the result with a range status.
// One word at a time; reset (synchronous, active low) restores the size
// registers to 128 and leaves the frame store contents undefined.
module bilinear_image_resizer_top
  import bir_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [COORD_W-1:0]    in_row,
  input  logic [COORD_W-1:0]    in_col,
  input  logic signed [PIX_W-1:0] in_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VAL_W-1:0]      out_value,
  output logic                  out_status
);

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int TOP_W   = PIX_W + FRAC_W + 1;
  localparam int DIF_W   = TOP_W + 1;
  localparam int S_W     = 50;
  localparam int T_W     = DVD_W + COORD_W;       // (2o+1)*ratio / 2
  localparam int WHOLE_W = T_W - FRAC_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_MMUL = 4'd2;
  localparam logic [3:0] S_MAP  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_HTOP = 4'd5;
  localparam logic [3:0] S_HBOT = 4'd6;
  localparam logic [3:0] S_VBOT = 4'd7;
  localparam logic [3:0] S_VDIF = 4'd8;
  localparam logic [3:0] S_VMUL = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_r, state_nxt;

  // Configuration registers
  logic [IN_W-1:0]   src_rows_r, src_cols_r;
  logic [DEST_W-1:0] dest_rows_r, dest_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r  <= SRC_RST;
      src_cols_r  <= SRC_RST;
      dest_rows_r <= DEST_RST;
      dest_cols_r <= DEST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_ROWS:  src_rows_r  <= cfg_data[IN_W-1:0];
        REG_SRC_COLS:  src_cols_r  <= cfg_data[IN_W-1:0];
        REG_DEST_ROWS: dest_rows_r <= cfg_data[DEST_W-1:0];
        REG_DEST_COLS: dest_cols_r <= cfg_data[DEST_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes to their legal ranges
  logic [IN_W-1:0]   in_r, in_c;
  logic [DEST_W-1:0] t_r, t_c;

  always_comb begin
    if (src_rows_r == '0) in_r = IN_W'(1);
    else if (32'(src_rows_r) > MAX_ROWS) in_r = IN_W'(MAX_ROWS);
    else in_r = src_rows_r;

    if (src_cols_r == '0) in_c = IN_W'(1);
    else if (32'(src_cols_r) > MAX_COLS) in_c = IN_W'(MAX_COLS);
    else in_c = src_cols_r;

    if (dest_rows_r == '0) t_r = DEST_W'(1);
    else if (dest_rows_r > DEST_MAX) t_r = DEST_MAX;
    else t_r = dest_rows_r;

    if (dest_cols_r == '0) t_c = DEST_W'(1);
    else if (dest_cols_r > DEST_MAX) t_c = DEST_MAX;
    else t_c = dest_cols_r;
  end

  // Input decode
  logic in_acc, wr_acc, req_acc, wr_inside, req_outside;

  assign in_ready    = state_r == S_IDLE;
  assign in_acc      = in_valid && in_ready;
  assign wr_acc      = in_acc && (in_func == FUNC_WRITE);
  assign req_acc     = in_acc && (in_func == FUNC_REQUEST);
  assign wr_inside   = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
  assign req_outside = ({1'b0, in_row} >= t_r) || ({1'b0, in_col} >= t_c);

  // Request coordinates and mapping results
  logic [COORD_W-1:0] row_r, col_r;
  logic               axis_r;             // 0 row, 1 column
  logic [IN_W-1:0]    r0_r, r1_r, c0_r, c1_r;
  logic [FRAC_W-1:0]  fy_r, fx_r;
  logic [2:0]         rd_cnt_r;

  // Shared divider
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [DEST_W-1:0] div_dvs;

  assign div_start = (req_acc && !req_outside) || (state_r == S_MAP && !axis_r);
  assign div_dvd   = (state_r == S_IDLE) ? {in_r, FRAC_W'(0)} : {in_c, FRAC_W'(0)};
  assign div_dvs   = (state_r == S_IDLE) ? t_r : t_c;

  bir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Shared multiplier
  logic signed [PIX_W-1:0]   v_r [4];
  logic signed [PIX_W:0]     hd0, hd1;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p, prod_r;
  logic signed [TOP_W-1:0]   top_r, bot_r;
  logic signed [DIF_W-1:0]   diff_r;
  logic [COORD_W-1:0]        map_o;

  assign map_o = axis_r ? col_r : row_r;
  assign hd0   = (PIX_W+1)'(v_r[1]) - (PIX_W+1)'(v_r[0]);
  assign hd1   = (PIX_W+1)'(v_r[3]) - (PIX_W+1)'(v_r[2]);

  always_comb begin
    case (state_r)
      S_MMUL: begin
        mul_a = $signed({{(MUL_A_W-DVD_W){1'b0}}, div_quo});
        mul_b = $signed({{(MUL_B_W-COORD_W-1){1'b0}}, map_o, 1'b1});
      end
      S_HTOP: begin
        mul_a = MUL_A_W'(hd0);
        mul_b = $signed({{(MUL_B_W-FRAC_W){1'b0}}, fx_r});
      end
      S_HBOT: begin
        mul_a = MUL_A_W'(hd1);
        mul_b = $signed({{(MUL_B_W-FRAC_W){1'b0}}, fx_r});
      end
      default: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = $signed({{(MUL_B_W-FRAC_W){1'b0}}, fy_r});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Map to source: src = (2o+1)*ratio/2 - 0.5, clamp at both edges
  logic [T_W-1:0]     map_t, map_src;
  logic [WHOLE_W-1:0] map_whole;
  logic [IN_W-1:0]    map_in, map_last, map_i0, map_i1;
  logic [FRAC_W-1:0]  map_f;
  logic               map_neg, map_edge;

  assign map_t     = prod_r[T_W:1];
  assign map_neg   = map_t < T_W'(32768);
  assign map_src   = map_t - T_W'(32768);
  assign map_whole = map_src[T_W-1:FRAC_W];
  assign map_in    = axis_r ? in_c : in_r;
  assign map_last  = map_in - IN_W'(1);
  assign map_edge  = map_whole >= WHOLE_W'(map_last);

  always_comb begin
    if (map_neg) begin
      map_i0 = '0;
      map_i1 = '0;
      map_f  = '0;
    end else if (map_edge) begin
      map_i0 = map_last;
      map_i1 = map_last;
      map_f  = '0;
    end else begin
      map_i0 = map_whole[IN_W-1:0];
      map_i1 = map_whole[IN_W-1:0] + IN_W'(1);
      map_f  = map_src[FRAC_W-1:0];
    end
  end

  // Frame store, single port
  logic signed [PIX_W-1:0] mem [DEPTH];
  logic signed [PIX_W-1:0] rdata_r;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [IN_W-1:0]         rd_row, rd_col;

  assign mem_we  = wr_acc && wr_inside;
  assign mem_re  = (state_r == S_RD) && !rd_cnt_r[2];
  assign rd_row  = rd_cnt_r[1] ? r1_r : r0_r;
  assign rd_col  = rd_cnt_r[0] ? c1_r : c0_r;
  assign wr_addr = ADDR_W'(in_row * MAX_COLS + in_col);
  assign rd_addr = ADDR_W'(rd_row * MAX_COLS + rd_col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_pixel;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Final sum and round half up
  logic signed [S_W-1:0] fin_s;
  logic [S_W-1:0]        fin_rnd;
  logic                  fin_pos;

  assign fin_s   = (S_W'(top_r) <<< FRAC_W) + S_W'(prod_r);
  assign fin_pos = !fin_s[S_W-1] && (fin_s != '0);
  assign fin_rnd = $unsigned(fin_s) + (S_W'(1) << (2*FRAC_W - 1));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (req_acc) state_nxt = req_outside ? S_DONE : S_DIV;
      S_DIV:  if (div_done) state_nxt = S_MMUL;
      S_MMUL: state_nxt = S_MAP;
      S_MAP:  state_nxt = axis_r ? S_RD : S_DIV;
      S_RD:   if (rd_cnt_r == 3'd4) state_nxt = S_HTOP;
      S_HTOP: state_nxt = S_HBOT;
      S_HBOT: state_nxt = S_VBOT;
      S_VBOT: state_nxt = S_VDIF;
      S_VDIF: state_nxt = S_VMUL;
      S_VMUL: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic             out_valid_r;
  logic [VAL_W-1:0] res_value_r, out_value_r;
  logic             res_status_r, out_status_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (req_acc) begin
        axis_r <= 1'b0;
      end else if (state_r == S_MAP) begin
        axis_r <= 1'b1;
      end
      if (state_r == S_RD) begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
      end else begin
        rd_cnt_r <= '0;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      row_r        <= in_row;
      col_r        <= in_col;
      res_value_r  <= '0;
      res_status_r <= req_outside ? STATUS_RANGE : STATUS_OK;
    end

    if (state_r == S_MMUL || state_r == S_HTOP || state_r == S_HBOT ||
        state_r == S_VMUL) begin
      prod_r <= mul_p;
    end

    // Latch neighbors and fraction of the current axis
    if (state_r == S_MAP) begin
      if (axis_r) begin
        c0_r <= map_i0;
        c1_r <= map_i1;
        fx_r <= map_f;
      end else begin
        r0_r <= map_i0;
        r1_r <= map_i1;
        fy_r <= map_f;
      end
    end

    // Capture each read word in the cycle after its address
    if (state_r == S_RD && rd_cnt_r != 3'd0) begin
      v_r[2'(rd_cnt_r - 3'd1)] <= rdata_r;
    end

    if (state_r == S_HBOT) begin
      top_r <= (TOP_W'(v_r[0]) <<< FRAC_W) + TOP_W'(prod_r);
    end
    if (state_r == S_VBOT) begin
      bot_r <= (TOP_W'(v_r[2]) <<< FRAC_W) + TOP_W'(prod_r);
    end
    if (state_r == S_VDIF) begin
      diff_r <= DIF_W'(bot_r) - DIF_W'(top_r);
    end

    if (state_r == S_FIN) begin
      res_value_r <= fin_pos ? fin_rnd[2*FRAC_W +: VAL_W] : '0;
    end

    // Load the output word
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

@@ sv/bir_checker.sv @@
module bir_checker
  import bir_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_func,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_value,
  input logic             out_status
);

  // A range error carries a zero value
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_RANGE) |-> out_value == '0)
    else $error("range error word with nonzero value");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result word changed");

  // Keep taking words after a pixel write
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_WRITE) |=> in_ready)
    else $error("ready dropped after a write word");

  // Drop ready while a request is in flight
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_REQUEST) |=> !in_ready)
    else $error("ready held after a request word");

endmodule

bind bilinear_image_resizer_top bir_checker u_bir_checker (.*);

@@ bench/tb_bilinear_image_resizer_top.sv @@
`timescale 1ns / 1ps

module tb_bilinear_image_resizer_top;
  import bir_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int STORE_DEPTH    = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int PHASE_ITEMS    = 30;

  typedef struct {
    logic                     func;
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic signed [PIX_W-1:0]  pixel;
    bit                       hold;  // wait for all results before sending
  } word_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             status;
  } pix_result_t;

  typedef struct {
    int unsigned src_r;
    int unsigned src_c;
    int unsigned dst_r;
    int unsigned dst_c;
  } sizes_t;

  typedef struct {
    int unsigned lo;
    int unsigned hi;
    longint      frac;
  } tap_t;

  // DUT connections
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_SRC_ROWS;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_func = FUNC_WRITE;
  logic [COORD_W-1:0]      in_row = '0;
  logic [COORD_W-1:0]      in_col = '0;
  logic signed [PIX_W-1:0] in_pixel = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [VAL_W-1:0]        out_value;
  logic                    out_status;

  // Predictor state: size registers (raw bits) and frame store image
  logic [IN_W-1:0]         src_rows_q = SRC_RST;
  logic [IN_W-1:0]         src_cols_q = SRC_RST;
  logic [DEST_W-1:0]       dst_rows_q = DEST_RST;
  logic [DEST_W-1:0]       dst_cols_q = DEST_RST;
  logic signed [PIX_W-1:0] frame_img [STORE_DEPTH];

  // Generator view of which store entries hold a written pixel
  bit                      img_written [STORE_DEPTH];

  word_t       pending_words[$];
  pix_result_t expected_pixels[$];
  word_t       cur_word;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;
  int          mismatch_cnt = 0;
  int          idle_cnt = 0;

  bilinear_image_resizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

  always #10 clk = ~clk;

  function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic sizes_t eff_sizes();
    sizes_t z;
    z.src_r = clamp_size(32'(src_rows_q), MAX_ROWS_DEF);
    z.src_c = clamp_size(32'(src_cols_q), MAX_COLS_DEF);
    z.dst_r = clamp_size(32'(dst_rows_q), int'(DEST_MAX));
    z.dst_c = clamp_size(32'(dst_cols_q), int'(DEST_MAX));
    return z;
  endfunction

  // Map one output coordinate to its two source taps and Q16 fraction
  function automatic tap_t map_axis(input int unsigned o, input int unsigned n,
                                    input int unsigned tgt);
    tap_t t;
    longint unsigned ratio;
    longint unsigned prod;
    longint pos;
    ratio = (64'(n) << 16) / 64'(tgt);
    prod = ((64'(o) * 2 + 1) * ratio) >> 1;
    pos = longint'(prod) - 64'sd32768;
    if (pos < 0) begin
      t.lo = 0;
      t.hi = 0;
      t.frac = 0;
    end else if ((pos >>> 16) >= longint'(n) - 1) begin
      t.lo = n - 1;
      t.hi = n - 1;
      t.frac = 0;
    end else begin
      t.lo = 32'(pos >>> 16);
      t.hi = t.lo + 1;
      t.frac = pos & 64'hFFFF;
    end
    return t;
  endfunction

  function automatic longint pix_at(input int unsigned r, input int unsigned c);
    return longint'(frame_img[r * MAX_COLS_DEF + c]);
  endfunction

  // Update the image or compute the blended pixel for one accepted word
  task automatic take_word(input word_t w);
    pix_result_t res;
    sizes_t      z;
    tap_t        ty;
    tap_t        tx;
    longint      top;
    longint      bot;
    longint      s;
    if (w.func == FUNC_WRITE) begin
      if (w.row < MAX_ROWS_DEF && w.col < MAX_COLS_DEF)
        frame_img[int'(w.row) * MAX_COLS_DEF + int'(w.col)] = w.pixel;
    end else begin
      z = eff_sizes();
      if (w.row >= z.dst_r || w.col >= z.dst_c) begin
        res.value = '0;
        res.status = STATUS_RANGE;
      end else begin
        ty = map_axis(32'(w.row), z.src_r, z.dst_r);
        tx = map_axis(32'(w.col), z.src_c, z.dst_c);
        top = pix_at(ty.lo, tx.lo) * (65536 - tx.frac) + pix_at(ty.lo, tx.hi) * tx.frac;
        bot = pix_at(ty.hi, tx.lo) * (65536 - tx.frac) + pix_at(ty.hi, tx.hi) * tx.frac;
        s = top * (65536 - ty.frac) + bot * ty.frac;
        if (s <= 0)
          res.value = '0;
        else
          res.value = VAL_W'((s + 64'sd2147483648) >>> 32);
        res.status = STATUS_OK;
      end
      expected_pixels.push_back(res);
    end
  endtask

  task automatic log_mismatch(input string what, input pix_result_t want);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %0d at %0t: %s: expected value %0d status %0d, got value %0d status %0d",
               mismatch_cnt, $realtime, what, want.value, want.status, out_value, out_status);
  endtask

  // Most gaps short, a few long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 19))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic push_write(input int unsigned r, input int unsigned c,
                            input logic signed [PIX_W-1:0] p);
    word_t w;
    w.func = FUNC_WRITE;
    w.row = COORD_W'(r);
    w.col = COORD_W'(c);
    w.pixel = p;
    w.hold = 1'b0;
    pending_words.push_back(w);
    if (r < MAX_ROWS_DEF && c < MAX_COLS_DEF)
      img_written[r * MAX_COLS_DEF + c] = 1'b1;
  endtask

  // Fill any unwritten neighbour first so no request reads an empty entry
  task automatic push_request(input int unsigned r, input int unsigned c, input bit hold);
    word_t  w;
    sizes_t z;
    tap_t   ty;
    tap_t   tx;
    int unsigned rr [2];
    int unsigned cc [2];
    z = eff_sizes();
    if (r < z.dst_r && c < z.dst_c) begin
      ty = map_axis(r, z.src_r, z.dst_r);
      tx = map_axis(c, z.src_c, z.dst_c);
      rr[0] = ty.lo;
      rr[1] = ty.hi;
      cc[0] = tx.lo;
      cc[1] = tx.hi;
      foreach (rr[i])
        foreach (cc[j])
          if (!img_written[rr[i] * MAX_COLS_DEF + cc[j]])
            push_write(rr[i], cc[j], rand_pixel());
    end
    w.func = FUNC_REQUEST;
    w.row = COORD_W'(r);
    w.col = COORD_W'(c);
    w.pixel = PIX_W'($urandom);
    w.hold = hold;
    pending_words.push_back(w);
  endtask

  task automatic fill_random(input int count);
    sizes_t z;
    int     kind;
    int unsigned r;
    int unsigned c;
    z = eff_sizes();
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        // writes: mostly inside the source image, some ignored noise
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(MAX_ROWS_DEF, 1023);
            c = $urandom_range(0, 1023);
          end else begin
            r = $urandom_range(0, 1023);
            c = $urandom_range(MAX_COLS_DEF, 1023);
          end
        end else begin
          r = $urandom_range(0, z.src_r - 1);
          c = $urandom_range(0, z.src_c - 1);
        end
        push_write(r, c, rand_pixel());
      end else if (kind < 40 && (z.dst_r < 1024 || z.dst_c < 1024)) begin
        if (z.dst_r < 1024 && (z.dst_c == 1024 || $urandom_range(0, 1) == 0)) begin
          r = $urandom_range(z.dst_r, 1023);
          c = $urandom_range(0, 1023);
        end else begin
          r = $urandom_range(0, 1023);
          c = $urandom_range(z.dst_c, 1023);
        end
        push_request(r, c, $urandom_range(0, 32) == 0);
      end else begin
        r = $urandom_range(0, z.dst_r - 1);
        c = $urandom_range(0, z.dst_c - 1);
        push_request(r, c, $urandom_range(0, 32) == 0);
      end
    end
  endtask

  // Wait until every word is sent and every result has come, then let
  // the block finish any trailing write
  task automatic wait_idle();
    @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_SRC_ROWS:  src_rows_q = v[IN_W-1:0];
      REG_SRC_COLS:  src_cols_q = v[IN_W-1:0];
      REG_DEST_ROWS: dst_rows_q = v[DEST_W-1:0];
      REG_DEST_COLS: dst_cols_q = v[DEST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(input int unsigned sr, input int unsigned sc,
                           input int unsigned dr, input int unsigned dc);
    wait_idle();
    write_reg(REG_SRC_ROWS, CFG_DATA_W'(sr));
    write_reg(REG_SRC_COLS, CFG_DATA_W'(sc));
    write_reg(REG_DEST_ROWS, CFG_DATA_W'(dr));
    write_reg(REG_DEST_COLS, CFG_DATA_W'(dc));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: present one word at a time, predict on acceptance
  always @(posedge clk) begin : drive_words
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        take_word(cur_word);
        if ($urandom_range(0, 63) == 0)
          src_burst = !src_burst;
        gap_left = (!src_burst && $urandom_range(0, 1) == 0) ? draw_gap() : 0;
      end
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && pending_words.size() != 0 &&
            !(pending_words[0].hold && expected_pixels.size() != 0)) begin
          cur_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_word.func;
          in_row <= cur_word.row;
          in_col <= cur_word.col;
          in_pixel <= cur_word.pixel;
        end else begin
          if (gap_left > 0)
            gap_left--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          want.value = '0;
          want.status = STATUS_OK;
          log_mismatch("result with nothing expected", want);
        end else begin
          want = expected_pixels.pop_front();
          if (out_value !== want.value)
            log_mismatch("value differs", want);
          else if (out_status !== want.status)
            log_mismatch("status differs", want);
        end
      end
      if ($urandom_range(0, 63) == 0)
        sink_burst = !sink_burst;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!sink_burst && $urandom_range(0, 99) < 15)
          stall_left = draw_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_bilinear_image_resizer_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    foreach (frame_img[i]) frame_img[i] = '0;
    foreach (img_written[i]) img_written[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corners with extreme pixels, ignored writes, edge clamping,
    // out-of-range requests, at the reset sizes
    push_write(0, 0, 16'sh7FFF);
    push_write(0, 127, 16'sh8000);
    push_write(127, 0, 16'sh0001);
    push_write(127, 127, 16'shFFFF);
    push_write(64, 64, 16'sh0000);
    push_write(1023, 1023, 16'sh5555);
    push_write(128, 5, 16'shAAAA);
    push_write(7, 128, 16'sh0001);
    push_request(0, 0, 1'b0);
    push_request(127, 127, 1'b0);
    push_request(127, 0, 1'b1);
    push_request(0, 127, 1'b0);
    push_request(64, 64, 1'b0);
    push_request(128, 0, 1'b0);
    push_request(0, 128, 1'b0);
    push_request(1023, 1023, 1'b0);

    // Largest upscale: negative source coordinate and past the last pixel
    set_sizes(2, 2, 1024, 1024);
    push_write(0, 0, 16'sh8000);
    push_write(0, 1, 16'sh7FFF);
    push_write(1, 0, 16'sh8000);
    push_write(1, 1, 16'sh8000);
    push_request(0, 0, 1'b0);
    push_request(1023, 1023, 1'b0);
    push_request(511, 512, 1'b0);
    push_request(1023, 0, 1'b0);
    fill_random(PHASE_ITEMS);

    set_sizes(1, 1, 1, 1);
    fill_random(PHASE_ITEMS);
    set_sizes(0, 0, 0, 0);
    fill_random(PHASE_ITEMS);
    set_sizes(255, 255, 2047, 2047);
    fill_random(PHASE_ITEMS);
    set_sizes(128, 128, 1, 1);
    fill_random(PHASE_ITEMS);
    set_sizes(3, 128, 1024, 7);
    fill_random(PHASE_ITEMS);

    // Random sizes: mostly small images, a few raw values across the full width
    for (int p = 0; p < 9; p++) begin
      if ($urandom_range(0, 3) == 0)
        set_sizes($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 2047), $urandom_range(0, 2047));
      else
        set_sizes($urandom_range(1, 8), $urandom_range(1, 8),
                  $urandom_range(1, 24), $urandom_range(1, 24));
      fill_random(PHASE_ITEMS);
    end

    wait_idle();
    if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
      $display("tb_bilinear_image_resizer_top passed");
    end else begin
      $display("tb_bilinear_image_resizer_top failed");
    end
    $finish;
  end

endmodule
